// ----- src/cpib_pkg.sv -----
// Shared types and constants for the charge port idle cutoff and level blink block.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps

package cpib_pkg;

	localparam int SAMPLE_W     = 10;
	localparam int READ_W       = SAMPLE_W + 1;
	localparam int THR_W        = 11;
	localparam int LIMIT_W      = 16;
	localparam int PERIOD_W     = 8;
	localparam int STEP_W       = 11;
	localparam int HALF_W       = PERIOD_W;
	localparam int PROD_W       = HALF_W + STEP_W;
	localparam int SW_W         = 4;
	localparam int OUT_W        = 4;
	localparam int SAMPLE_PORTS = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int PORTS_DEF    = 4;

	localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(50);
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(50);
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(40);
	localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_THRESHOLD = 2'd0,
		CFG_CUTOFF_LIMIT  = 2'd1,
		CFG_BLINK_PERIOD  = 2'd2,
		CFG_LEVEL_STEP    = 2'd3
	} cpib_cfg_idx_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_TICK   = 1'b1
	} cpib_cmd_t;

	typedef struct packed {
		logic [THR_W-1:0]    low_threshold;
		logic [LIMIT_W-1:0]  cutoff_limit;
		logic [PERIOD_W-1:0] blink_period;
		logic [STEP_W-1:0]   level_step;
	} cpib_cfg_t;

	// Per-transaction control fanned out to every port slice.
	typedef struct packed {
		logic              fire;
		logic              tick;
		logic              odd;
		logic [HALF_W-1:0] half;
	} cpib_ctrl_t;

endpackage

// ----- src/cpib_sample_if.sv -----
// Input channel: one command with four readings and the switch levels.
// Depends on cpib_pkg for field widths.
`timescale 1ns / 1ps

interface cpib_sample_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [cpib_pkg::SAMPLE_W-1:0] sample_a;
	logic [cpib_pkg::SAMPLE_W-1:0] sample_b;
	logic [cpib_pkg::SAMPLE_W-1:0] sample_c;
	logic [cpib_pkg::SAMPLE_W-1:0] sample_d;
	logic [cpib_pkg::SW_W-1:0]     switch_levels;

	modport source (output valid, command, sample_a, sample_b, sample_c, sample_d,
		switch_levels, input ready);
	modport sink (input valid, command, sample_a, sample_b, sample_c, sample_d,
		switch_levels, output ready);
endinterface

// ----- src/cpib_result_if.sv -----
// Result channel: cutoff and LED bits for every accepted item.
// Depends on cpib_pkg for field widths.
`timescale 1ns / 1ps

interface cpib_result_if;
	logic                       valid;
	logic                       ready;
	logic [cpib_pkg::OUT_W-1:0] cutoff_outputs;
	logic [cpib_pkg::OUT_W-1:0] level_leds;

	modport source (output valid, cutoff_outputs, level_leds, input ready);
	modport sink (input valid, cutoff_outputs, level_leds, output ready);
endinterface

// ----- src/cpib_blink.sv -----
// Blink counter: wraps at the configured period and supplies the LED phase.
// Depends on cpib_pkg.
`timescale 1ns / 1ps

module cpib_blink (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [cpib_pkg::PERIOD_W-1:0]   period,
	output logic                            odd,
	output logic [cpib_pkg::HALF_W-1:0]     half
);
	import cpib_pkg::*;

	logic [PERIOD_W-1:0] count_q;
	logic [PERIOD_W-1:0] count_inc;
	logic [PERIOD_W-1:0] count_next;
	logic [PERIOD_W:0]   half_sum;

	assign count_inc  = count_q + PERIOD_W'(1);
	assign count_next = (count_inc >= period) ? '0 : count_inc;
	assign odd        = count_next[0];
	assign half_sum   = {1'b0, count_next} + (PERIOD_W+1)'(1);
	assign half       = half_sum[PERIOD_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (step) begin
			count_q <= count_next;
		end
	end

endmodule

// ----- src/cpib_port.sv -----
// One port slice: stored reading, idle counter, cutoff bit and LED bit.
// Depends on cpib_pkg for the control and configuration structs.
`timescale 1ns / 1ps

module cpib_port #(
	parameter bit HAS_SAMPLE = 1'b1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cpib_pkg::cpib_ctrl_t            ctrl,
	input  cpib_pkg::cpib_cfg_t             cfg,
	input  logic [cpib_pkg::SAMPLE_W-1:0]   sample,
	input  logic                            switch_level,
	output logic                            cutoff,
	output logic                            led
);
	import cpib_pkg::*;

	logic [READ_W-1:0]  reading_q;
	logic [LIMIT_W-1:0] count_q;
	logic               cutoff_q;
	logic               led_q;

	logic [READ_W-1:0]  reading_new;
	logic [LIMIT_W-1:0] count_inc;
	logic [LIMIT_W-1:0] count_new;
	logic [PROD_W-1:0]  product;
	logic               lit;
	logic               can_count;

	assign reading_new = (!ctrl.tick && HAS_SAMPLE) ? {sample, 1'b0} : reading_q;

	// The counter stops one past the limit so the cutoff fires exactly once per idle run.
	assign can_count = ctrl.tick && (reading_q < cfg.low_threshold)
		&& (count_q <= cfg.cutoff_limit) && (count_q != '1);
	assign count_inc = can_count ? count_q + LIMIT_W'(1) : count_q;
	assign count_new = (reading_new >= cfg.low_threshold) ? '0 : count_inc;

	assign cutoff = (count_new == cfg.cutoff_limit) || (cutoff_q && switch_level);

	// half <= reading / step is the same as half * step <= reading; a zero step always lights.
	assign product = PROD_W'(ctrl.half) * PROD_W'(cfg.level_step);
	assign lit     = product <= PROD_W'(reading_q);

	always_comb begin
		led = led_q;
		if (ctrl.tick) begin
			led = ctrl.odd ? (led_q || lit) : 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_q <= '0;
			count_q   <= '0;
			cutoff_q  <= 1'b0;
			led_q     <= 1'b1;
		end else if (ctrl.fire) begin
			reading_q <= reading_new;
			count_q   <= count_new;
			cutoff_q  <= cutoff;
			led_q     <= led;
		end
	end

endmodule

// ----- src/charge_port_idle_cutoff_and_level_blink_core.sv -----
// Charge port monitor: one item is accepted every clock cycle while the result side drains.
// Each item goes from the input register through a single pass of each port slice (an 8 by
// 11 bit multiply and compare, the idle counter update and the cutoff compare) into the
// result register. A full result register that is not taken stalls the input register.
// Configuration registers reset to threshold 50, limit 50, period 40, step 100 and are
// written directly through the write port; the user must write them only while no
// transaction is in flight, and the block itself does not enforce this.
`timescale 1ns / 1ps

module charge_port_idle_cutoff_and_level_blink_core #(
	parameter int PORTS = cpib_pkg::PORTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	cpib_sample_if.sink                       sample_ch,
	cpib_result_if.source                     result_ch,
	input  logic                              cfg_write_en,
	input  logic [cpib_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cpib_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cpib_pkg::*;

	cpib_cfg_t  cfg_q;
	cpib_ctrl_t ctrl;

	logic                               valid_s1;
	logic                               cmd_s1;
	logic [SAMPLE_PORTS-1:0][SAMPLE_W-1:0] samples_s1;
	logic [SW_W-1:0]                    switch_s1;

	logic                 result_valid_q;
	logic [OUT_W-1:0]     cutoff_q;
	logic [OUT_W-1:0]     leds_q;

	logic                 advance;
	logic                 accept;
	logic                 blink_odd;
	logic [HALF_W-1:0]    blink_half;
	logic [PORTS-1:0]     cutoff_new;
	logic [PORTS-1:0]     led_new;
	logic [OUT_W-1:0]     cutoff_out;
	logic [OUT_W-1:0]     led_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_threshold <= THR_RESET;
			cfg_q.cutoff_limit  <= LIMIT_RESET;
			cfg_q.blink_period  <= PERIOD_RESET;
			cfg_q.level_step    <= STEP_RESET;
		end else if (cfg_write_en) begin
			unique case (cpib_cfg_idx_t'(cfg_index))
				CFG_LOW_THRESHOLD: cfg_q.low_threshold <= cfg_data[THR_W-1:0];
				CFG_CUTOFF_LIMIT:  cfg_q.cutoff_limit  <= cfg_data[LIMIT_W-1:0];
				CFG_BLINK_PERIOD:  cfg_q.blink_period  <= cfg_data[PERIOD_W-1:0];
				CFG_LEVEL_STEP:    cfg_q.level_step    <= cfg_data[STEP_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// The input register moves on whenever the result register is empty or being taken.
	assign advance         = valid_s1 && (!result_valid_q || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;
	assign accept          = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1        <= sample_ch.command;
			samples_s1[0] <= sample_ch.sample_a;
			samples_s1[1] <= sample_ch.sample_b;
			samples_s1[2] <= sample_ch.sample_c;
			samples_s1[3] <= sample_ch.sample_d;
			switch_s1     <= sample_ch.switch_levels;
		end
	end

	cpib_blink u_blink (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance && (cmd_s1 == CMD_TICK)),
		.period (cfg_q.blink_period),
		.odd    (blink_odd),
		.half   (blink_half)
	);

	assign ctrl.fire = advance;
	assign ctrl.tick = (cmd_s1 == CMD_TICK);
	assign ctrl.odd  = blink_odd;
	assign ctrl.half = blink_half;

	for (genvar p = 0; p < PORTS; p++) begin : g_port
		if (p < SAMPLE_PORTS) begin : g_fed
			cpib_port #(.HAS_SAMPLE(1'b1)) u_port (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.cfg          (cfg_q),
				.sample       (samples_s1[p]),
				.switch_level (switch_s1[p]),
				.cutoff       (cutoff_new[p]),
				.led          (led_new[p])
			);
		end else begin : g_unfed
			cpib_port #(.HAS_SAMPLE(1'b0)) u_port (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.cfg          (cfg_q),
				.sample       ('0),
				.switch_level (1'b1),
				.cutoff       (cutoff_new[p]),
				.led          (led_new[p])
			);
		end
	end

	for (genvar b = 0; b < OUT_W; b++) begin : g_out
		if (b < PORTS) begin : g_used
			assign cutoff_out[b] = cutoff_new[b];
			assign led_out[b]    = led_new[b];
		end else begin : g_unused
			assign cutoff_out[b] = 1'b0;
			assign led_out[b]    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cutoff_q <= cutoff_out;
			leds_q   <= led_out;
		end
	end

	assign result_ch.valid          = result_valid_q;
	assign result_ch.cutoff_outputs = cutoff_q;
	assign result_ch.level_leds     = leds_q;

	a_advance_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid_q)
		else $error("processed transaction did not reach the result register");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result_valid_q && !result_ch.ready) |=> (valid_s1 && $stable(cmd_s1)))
		else $error("input register lost a transaction during a result stall");

	a_no_advance_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_ch.ready) |-> !ctrl.fire)
		else $error("state updated while the result register was blocked");

endmodule
